/* hw/rtl/sba_pkg.sv */
package sba_pkg;

  // Field widths
  localparam int IDX_W   = 11;
  localparam int MAG_W   = 15;
  localparam int BAND_W  = 4;
  localparam int SUM_W   = 23;
  localparam int AVG_W   = 16;

  // Band layout
  localparam int NUM_BANDS = 12;
  localparam logic [IDX_W-1:0]  FIRST_BIN = 11'd6;
  localparam logic [IDX_W-1:0]  END_BIN   = 11'd513;
  localparam logic [BAND_W-1:0] LAST_BAND = 4'd11;

  localparam logic [SUM_W-1:0] SUM_MAX = 23'h7FFFFF;
  localparam logic [AVG_W-1:0] AVG_MAX = 16'hFFFF;

  // Lower bin edge of each band
  localparam logic [IDX_W-1:0] BAND_LO [NUM_BANDS] = '{
    11'd6, 11'd8, 11'd11, 11'd16, 11'd24, 11'd35,
    11'd51, 11'd75, 11'd110, 11'd161, 11'd237, 11'd349
  };

  // Reciprocals ceil(2^31 / d) for divisors 2, 3, 5, 8, 11, 16, 24, 35, 51, 76, 112, 163.
  // With a 23-bit sum the error term stays below 2^8, so floor(sum * r >> 31) is exact.
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 31;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] BAND_RECIP [NUM_BANDS] = '{
    31'd1073741824, 31'd715827883, 31'd429496730, 31'd268435456,
    31'd195225787,  31'd134217728, 31'd89478486,  31'd61356676,
    31'd42107523,   31'd28256364,  31'd19173962,  31'd13174747
  };

  // One classified item queued between front and back
  typedef struct packed {
    logic              hit;
    logic [BAND_W-1:0] band;
    logic [MAG_W-1:0]  mag;
    logic              frame_end;
  } entry_t;

  // Back-end status for observation
  typedef struct packed {
    logic              busy;
    logic [BAND_W-1:0] emit_idx;
  } back_status_t;

endpackage

/* hw/rtl/spectrum_band_averager.sv */
// Spectrum band averager. Each item carries one squared bin magnitude and its bin index;
// bins 6..512 are summed into twelve roughly logarithmic bands, other bins add nothing.
// An item with frame_end set is added first and then closes the frame: twelve results
// follow, band 0 first, each the band sum (saturating at 2^23-1) divided by the band's
// fixed divisor and saturated to 16 bits; last_band marks band 11, and all sums clear.
// Items are taken at one per cycle while the queue of QUEUE_DEPTH items has room. The
// accumulator has one read-modify-write port, so closing a frame holds the back end while
// it sweeps out all twelve bands (and while results stall) before it drains the queue
// again; each result passes a read stage, a product stage and an output register.
module spectrum_band_averager #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [sba_pkg::IDX_W-1:0]     bin_index,
  input  logic [sba_pkg::MAG_W-1:0]     magnitude,
  input  logic                          frame_end,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [sba_pkg::BAND_W-1:0]    band,
  output logic [sba_pkg::AVG_W-1:0]     band_average,
  output logic                          last_band
);

  logic                               q_push;
  logic                               q_full;
  logic                               q_pop;
  logic                               q_valid;
  sba_pkg::entry_t                    q_wdata;
  sba_pkg::entry_t                    q_rdata;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;
  sba_pkg::back_status_t              back_status;

  sba_front u_front (
    .bin_index  (bin_index),
    .magnitude  (magnitude),
    .frame_end  (frame_end),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .q_full     (q_full),
    .push       (q_push),
    .entry      (q_wdata)
  );

  sba_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata),
    .count (q_count)
  );

  sba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_rdata),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .band         (band),
    .band_average (band_average),
    .last_band    (last_band),
    .status       (back_status)
  );

`ifndef SYNTHESIS
  // Queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // A shown result is flagged last exactly when it is band 11
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_band == (band == sba_pkg::LAST_BAND)))
    else $error("last_band flag disagrees with band number");

  // The emission sweep ends only after issuing band 11
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    $fell(back_status.busy) |-> ($past(back_status.emit_idx) == sba_pkg::LAST_BAND))
    else $error("emission sweep ended early");
`endif

endmodule

/* hw/rtl/sba_front.sv */
module sba_front (
  input  logic [sba_pkg::IDX_W-1:0] bin_index,
  input  logic [sba_pkg::MAG_W-1:0] magnitude,
  input  logic                      frame_end,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      q_full,
  output logic                      push,
  output sba_pkg::entry_t           entry
);

  logic                         hit;
  logic [sba_pkg::BAND_W-1:0]   band_sel;

  // Find the band: the highest lower edge not above the index
  always_comb begin
    hit      = (bin_index >= sba_pkg::FIRST_BIN) && (bin_index < sba_pkg::END_BIN);
    band_sel = '0;
    for (int b = 1; b < sba_pkg::NUM_BANDS; b++) begin
      if (bin_index >= sba_pkg::BAND_LO[b]) begin
        band_sel = sba_pkg::BAND_W'(b);
      end
    end
  end

  // Drop items that neither add nor close a frame
  always_comb begin
    entry.hit       = hit;
    entry.band      = hit ? band_sel : '0;
    entry.mag       = magnitude;
    entry.frame_end = frame_end;
    item_stall      = q_full;
    push            = item_valid && !q_full && (hit || frame_end);
  end

endmodule

/* hw/rtl/sba_queue.sv */
module sba_queue #(
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  sba_pkg::entry_t                wdata,
  output logic                           full,
  input  logic                           pop,
  output logic                           valid,
  output sba_pkg::entry_t                rdata,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sba_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign valid   = (count != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/sba_back.sv */
module sba_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  sba_pkg::entry_t               q_entry,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [sba_pkg::BAND_W-1:0]    band,
  output logic [sba_pkg::AVG_W-1:0]     band_average,
  output logic                          last_band,
  output sba_pkg::back_status_t         status
);

  logic [sba_pkg::SUM_W-1:0]  sums [sba_pkg::NUM_BANDS];
  logic                       busy;
  logic [sba_pkg::BAND_W-1:0] emit_idx;

  // Divider pipeline: read stage, product stage, output register
  logic                        s1_valid;
  logic [sba_pkg::BAND_W-1:0]  s1_band;
  logic [sba_pkg::SUM_W-1:0]   s1_sum;
  logic                        s2_valid;
  logic [sba_pkg::BAND_W-1:0]  s2_band;
  logic [sba_pkg::PROD_W-1:0]  s2_prod;

  logic                        advance;
  logic [sba_pkg::BAND_W-1:0]  rd_addr;
  logic [sba_pkg::SUM_W-1:0]   rd_sum;
  logic [sba_pkg::SUM_W:0]     acc_wide;
  logic [sba_pkg::SUM_W-1:0]   acc_sat;
  logic [sba_pkg::SUM_W-1:0]   quot;
  logic [sba_pkg::AVG_W-1:0]   quot_sat;

  assign advance = !result_valid || !result_stall;
  assign pop     = q_valid && !busy;
  assign status  = '{busy: busy, emit_idx: emit_idx};

  // Single read port into the band sums
  always_comb begin
    rd_addr  = busy ? emit_idx : q_entry.band;
    rd_sum   = sums[rd_addr];
    acc_wide = {1'b0, rd_sum} + (sba_pkg::SUM_W+1)'(q_entry.mag);
    acc_sat  = acc_wide[sba_pkg::SUM_W] ? sba_pkg::SUM_MAX : acc_wide[sba_pkg::SUM_W-1:0];
    quot     = s2_prod[sba_pkg::PROD_W-1:sba_pkg::RECIP_SHIFT];
    quot_sat = (quot > sba_pkg::SUM_W'(sba_pkg::AVG_MAX)) ? sba_pkg::AVG_MAX
                                                           : quot[sba_pkg::AVG_W-1:0];
  end

  // Accumulate, then sweep the bands out and clear them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sba_pkg::NUM_BANDS; i++) begin
        sums[i] <= '0;
      end
      busy         <= 1'b0;
      emit_idx     <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop && q_entry.hit) begin
        sums[q_entry.band] <= acc_sat;
      end
      if (pop && q_entry.frame_end) begin
        busy     <= 1'b1;
        emit_idx <= '0;
      end
      if (busy && advance) begin
        sums[emit_idx] <= '0;
        if (emit_idx == sba_pkg::LAST_BAND) begin
          busy     <= 1'b0;
          emit_idx <= '0;
        end else begin
          emit_idx <= emit_idx + 1'b1;
        end
      end
      if (advance) begin
        s1_valid     <= busy;
        s2_valid     <= s1_valid;
        result_valid <= s2_valid;
      end
    end
  end

  // Advance the divider payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_band      <= emit_idx;
      s1_sum       <= rd_sum;
      s2_band      <= s1_band;
      s2_prod      <= sba_pkg::PROD_W'(s1_sum) *
                      sba_pkg::PROD_W'(sba_pkg::BAND_RECIP[s1_band]);
      band         <= s2_band;
      band_average <= quot_sat;
      last_band    <= (s2_band == sba_pkg::LAST_BAND);
    end
  end

endmodule
